/* src/sorted_key_table_search_insert_unit_macros.svh */
// Assertion macros for the sorted key table search and insert unit.
// Included by the top level for its concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef SORTED_KEY_TABLE_SEARCH_INSERT_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_SEARCH_INSERT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SKTSI_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("sktsi assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SKTSI_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("sktsi assertion failed");

`endif

/* src/sktsi_pkg.sv */
// Shared types, constants and codes for the sorted key table search and insert unit.
// No dependencies; imported by every module of the block but the generic RAM.
`timescale 1ns / 1ps

package sktsi_pkg;

    localparam int TABLE_DEPTH_DEF   = 64;
    localparam int PAYLOAD_WIDTH_DEF = 32;
    localparam int KEY_W             = 32;
    localparam int PAY_PORT_W        = 32;
    localparam int SLOT_W            = 6;
    localparam int CFG_W             = 6;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        t_opcode               opcode;
        logic [KEY_W-1:0]      key;
        logic [PAY_PORT_W-1:0] payload_in;
    } t_cmd;

    typedef struct packed {
        t_status               status;
        logic [SLOT_W-1:0]     slot_index;
        logic [PAY_PORT_W-1:0] payload_out;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_DECIDE,
        S_SHIFT,
        S_WRITE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    probe;
        logic    narrow;
        logic    mark_hit;
        logic    shift_start;
        logic    shift_step;
        logic    write_new;
        logic    finish;
        t_status status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic range_ok;
        logic key_eq;
        logic hit;
        logic is_insert;
        logic full;
        logic need_shift;
        logic shift_last;
    } t_dp_stat;

endpackage

/* src/sktsi_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module sktsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/sktsi_ctrl.sv */
// Sequencing state machine: search probes, result decision, table shift and write.
// Depends on sktsi_pkg for the state, command and status types.
`timescale 1ns / 1ps

module sktsi_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sktsi_pkg::t_dp_stat i_stat,
    output sktsi_pkg::t_dp_cmd  o_cmd,
    output logic                o_busy
);

    import sktsi_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                n_state = i_stat.range_ok ? S_CMP : S_DECIDE;
            end
            S_CMP: begin
                n_state = i_stat.key_eq ? S_DECIDE : S_SEARCH;
            end
            S_DECIDE: begin
                if (!i_stat.is_insert || i_stat.hit || i_stat.full) begin
                    n_state = S_IDLE;
                end else if (i_stat.need_shift) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_last) n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.status = ST_NOT_FOUND;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_SEARCH: begin
                o_cmd.probe = i_stat.range_ok;
            end
            S_CMP: begin
                o_cmd.mark_hit = i_stat.key_eq;
                o_cmd.narrow   = !i_stat.key_eq;
            end
            S_DECIDE: begin
                if (!i_stat.is_insert) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = i_stat.hit ? ST_FOUND : ST_NOT_FOUND;
                end else if (i_stat.hit) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_DUPLICATE;
                end else if (i_stat.full) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.shift_start = i_stat.need_shift;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
            end
            S_WRITE: begin
                o_cmd.write_new = 1'b1;
                o_cmd.finish    = 1'b1;
                o_cmd.status    = ST_INSERTED;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* src/sktsi_dp.sv */
// Datapath: key and payload stores, search bounds, shift index, fill count and result register.
// Depends on sktsi_pkg and sktsi_ram.
`timescale 1ns / 1ps

module sktsi_dp #(
    parameter int TABLE_DEPTH   = sktsi_pkg::TABLE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = sktsi_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sktsi_pkg::CFG_W-1:0]     i_cfg_data,
    input  sktsi_pkg::t_cmd                 i_cmd,
    input  sktsi_pkg::t_dp_cmd              i_dp_cmd,
    output sktsi_pkg::t_dp_stat             o_stat,
    output sktsi_pkg::t_result              o_result,
    output logic                            o_done
);

    import sktsi_pkg::*;

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int MW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int BW  = MW + 2;
    localparam int PSW = (PAYLOAD_WIDTH < PAY_PORT_W) ? PAYLOAD_WIDTH : PAY_PORT_W;
    localparam logic signed [BW-1:0] DEPTH_S = BW'(TABLE_DEPTH);
    localparam logic [CW-1:0]        DEPTH_C = CW'(TABLE_DEPTH);

    logic [CFG_W-1:0]       r_first;
    logic [CW-1:0]          r_fill;
    t_opcode                r_op;
    logic [KEY_W-1:0]       r_key;
    logic [PSW-1:0]         r_pay;
    logic signed [BW-1:0]   r_lo;
    logic signed [BW-1:0]   r_hi;
    logic signed [BW-1:0]   r_mid;
    logic [IW-1:0]          r_idx;
    logic                   r_hit;
    t_result                r_res;
    logic                   r_done;

    logic signed [BW-1:0]   mid;
    logic signed [BW-1:0]   fill_s;
    logic [KEY_W-1:0]       rd_key;
    logic [PSW-1:0]         rd_pay;
    logic                   we;
    logic [IW-1:0]          waddr;
    logic [KEY_W-1:0]       wkey;
    logic [PSW-1:0]         wpay;
    logic                   re;
    logic [IW-1:0]          raddr;

    assign mid    = (r_lo + r_hi) >>> 1;
    assign fill_s = signed'(BW'(r_fill));

    // Read port: probe at the midpoint, or walk the shift index downwards
    always_comb begin
        re    = i_dp_cmd.probe || i_dp_cmd.shift_start
             || (i_dp_cmd.shift_step && !o_stat.shift_last);
        raddr = r_idx - IW'(1);
        if (i_dp_cmd.probe) begin
            raddr = mid[IW-1:0];
        end else if (i_dp_cmd.shift_start) begin
            raddr = IW'(r_fill - CW'(1));
        end
    end

    // Write port: move an entry up one slot, or place the new entry
    always_comb begin
        we    = i_dp_cmd.shift_step || i_dp_cmd.write_new;
        waddr = r_lo[IW-1:0];
        wkey  = r_key;
        wpay  = r_pay;
        if (i_dp_cmd.shift_step) begin
            waddr = r_idx + IW'(1);
            wkey  = rd_key;
            wpay  = rd_pay;
        end
    end

    sktsi_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wkey),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_key)
    );

    sktsi_ram #(.WIDTH(PSW), .DEPTH(TABLE_DEPTH)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wpay),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_pay)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_we) r_first <= i_cfg_data;
            if (i_dp_cmd.write_new) r_fill <= r_fill + CW'(1);
            r_done <= i_dp_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_op  <= i_cmd.opcode;
            r_key <= i_cmd.key;
            r_pay <= i_cmd.payload_in[PSW-1:0];
            r_lo  <= signed'(BW'(r_first));
            r_hi  <= fill_s - BW'(1);
            r_hit <= 1'b0;
        end
        if (i_dp_cmd.probe) r_mid <= mid;
        if (i_dp_cmd.narrow) begin
            if (rd_key > r_key) r_hi <= r_mid - BW'(1);
            else                r_lo <= r_mid + BW'(1);
        end
        if (i_dp_cmd.mark_hit) r_hit <= 1'b1;
        if (i_dp_cmd.shift_start) r_idx <= IW'(r_fill - CW'(1));
        if (i_dp_cmd.shift_step)  r_idx <= r_idx - IW'(1);
        if (i_dp_cmd.finish) begin
            r_res.status <= i_dp_cmd.status;
            case (i_dp_cmd.status)
                ST_FOUND: begin
                    r_res.slot_index  <= SLOT_W'(r_mid);
                    r_res.payload_out <= PAY_PORT_W'(rd_pay);
                end
                ST_DUPLICATE: begin
                    r_res.slot_index  <= SLOT_W'(r_mid);
                    r_res.payload_out <= '0;
                end
                ST_INSERTED: begin
                    r_res.slot_index  <= SLOT_W'(r_lo);
                    r_res.payload_out <= '0;
                end
                default: begin
                    r_res.slot_index  <= '0;
                    r_res.payload_out <= '0;
                end
            endcase
        end
    end

    assign o_stat.range_ok   = (r_lo <= r_hi);
    assign o_stat.key_eq     = (rd_key == r_key);
    assign o_stat.hit        = r_hit;
    assign o_stat.is_insert  = (r_op == OP_INSERT);
    assign o_stat.full       = (r_fill >= DEPTH_C) || (r_lo >= DEPTH_S);
    assign o_stat.need_shift = (r_lo < fill_s);
    assign o_stat.shift_last = (r_idx == r_lo[IW-1:0]);

    assign o_result = r_res;
    assign o_done   = r_done;

endmodule

/* src/sorted_key_table_search_insert_unit.sv */
// Sorted key table, binary-search lookup and ordered insert, one item at a time. Steps:
// accept, a read and a compare per probe, one closing search on a miss, decide, result beat;
// an insert adds a shift step per entry moved up and a write step. For 64 entries a lookup
// makes at most 7 probes and an insert moves at most 63 entries; busy drops in the
// result-beat cycle, so a new item can be accepted while the last result beat is out.
// Synchronous active-low reset empties the table (fill count zero) and clears first_index.
`timescale 1ns / 1ps

module sorted_key_table_search_insert_unit #(
    parameter int TABLE_DEPTH   = sktsi_pkg::TABLE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = sktsi_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Command channel: a beat is taken when start is high and busy is low
    input  logic                        start,
    output logic                        busy,
    input  sktsi_pkg::t_cmd             i_cmd,
    // Result channel: one beat per item, valid for exactly one cycle
    output logic                        o_done,
    output sktsi_pkg::t_result          o_result,
    // Configuration write channel for first_index
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sktsi_pkg::CFG_W-1:0] i_cfg_data
);

    import sktsi_pkg::*;

`include "sorted_key_table_search_insert_unit_macros.svh"

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     cmd_beat;

    // Take a command only while the sequencer is idle
    assign cmd_beat    = start && !busy;
    // Hold configuration writes off while an item is in flight
    assign o_cfg_ready = !busy;

    // Controller: walks the probe, decide, shift and write phases
    sktsi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmd_beat),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // Datapath: stores, bounds, fill count and the registered result
    sktsi_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (i_cmd),
        .i_dp_cmd   (dp_cmd),
        .o_stat     (dp_stat),
        .o_result   (o_result),
        .o_done     (o_done)
    );

    // A result beat arrives only once the sequencer has gone back to idle
    `SKTSI_ASSERT_NOW(a_done_when_idle, o_done, !busy)
    // An accepted command keeps the unit busy in the following cycle
    `SKTSI_ASSERT_NEXT(a_beat_sets_busy, cmd_beat, busy && !o_done)
    // One result per item: result beats never come back to back
    `SKTSI_ASSERT_NEXT(a_single_result, o_done, !o_done)

endmodule

/* tb/tb.sv */
// Self-checking bench for the sorted key table search and insert unit.
// Needs sktsi_pkg and sorted_key_table_search_insert_unit; prediction is held in a small class.
`timescale 1ns / 1ps

module tb;
    import sktsi_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int TAIL_CYCLES  = 100;

    // Mirror of the table contents, the fill count and first_index, plus the queue
    // of results still owed by the block.
    class sorted_table_book;
        logic [KEY_W-1:0]      keys     [DEPTH];
        logic [PAY_PORT_W-1:0] payloads [DEPTH];
        bit                    written  [DEPTH];
        int                    fill;
        int                    first_slot;
        t_result               awaited  [$];
        int                    errors;

        function new();
            fill       = 0;
            first_slot = 0;
            errors     = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        // Binary search of [first_slot, fill-1]; a miss leaves the final low bound in pos.
        function bit search(input logic [KEY_W-1:0] key, output int pos);
            int lo;
            int hi;
            int mid;
            lo = first_slot;
            hi = fill - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (keys[mid] == key) begin
                    pos = mid;
                    return 1'b1;
                end
                if (keys[mid] > key) hi = mid - 1;
                else lo = mid + 1;
            end
            pos = lo;
            return 1'b0;
        endfunction

        // Every slot that a search may probe has been written.
        function bit range_written(input int from);
            for (int i = from; i < fill; i++)
                if (!written[i]) return 1'b0;
            return 1'b1;
        endfunction

        function void note_command(input t_cmd c);
            t_result r;
            int      pos;
            bit      hit;
            r   = '0;
            hit = search(c.key, pos);
            if (c.opcode == OP_LOOKUP) begin
                if (hit) begin
                    r.status      = ST_FOUND;
                    r.slot_index  = SLOT_W'(pos);
                    r.payload_out = payloads[pos];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end else if (hit) begin
                r.status     = ST_DUPLICATE;
                r.slot_index = SLOT_W'(pos);
            end else if (fill >= DEPTH || pos >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // Move entries up one slot, top first; a position above the fill moves nothing.
                for (int i = fill - 1; i >= pos; i--) begin
                    keys[i + 1]     = keys[i];
                    payloads[i + 1] = payloads[i];
                    written[i + 1]  = written[i];
                end
                keys[pos]     = c.key;
                payloads[pos] = c.payload_in;
                written[pos]  = 1'b1;
                fill++;
                r.status     = ST_INSERTED;
                r.slot_index = SLOT_W'(pos);
            end
            awaited.push_back(r);
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $display("%0t: result beat with nothing awaited: status %0d slot %0d payload %h",
                         $time, got.status, got.slot_index, got.payload_out);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.slot_index !== want.slot_index) begin
                $display("%0t: slot_index expected %0d actual %0d",
                         $time, want.slot_index, got.slot_index);
                errors++;
            end
            if (got.payload_out !== want.payload_out) begin
                $display("%0t: payload_out expected %h actual %h",
                         $time, want.payload_out, got.payload_out);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_cmd              i_cmd       = '0;
    logic              o_done;
    t_result           o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data  = '0;

    sorted_table_book book = new();

    sorted_key_table_search_insert_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result beats last one cycle and cannot be held off: take each at the edge ending it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) book.check_result(o_result);
    end

    // Hold the beat until the edge at which busy is low, then log it with the predictor.
    task automatic send_command(input t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        book.note_command(c);
    endtask

    // Drop start for a gap; leave it high otherwise so back-to-back beats keep flowing.
    task automatic hold_off(input int cycles);
        if (start) start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending and wait until every owed result has arrived and the block is idle.
    task automatic wait_drained();
        if (start) start <= 1'b0;
        @(posedge i_clk);
        while (book.awaited.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_first_slot(input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        book.first_slot = value;
    endtask

    // Keep every probed slot a written one: take the wanted lower bound only if the
    // searched range is fully written, else fall back to an empty range or the current one.
    function automatic logic [CFG_W-1:0] pick_first_slot(input int want);
        if (book.range_written(want)) return CFG_W'(want);
        if (book.fill < DEPTH) return CFG_W'(book.fill);
        return CFG_W'(book.first_slot);
    endfunction

    function automatic t_cmd cmd_of(input t_opcode op, input logic [KEY_W-1:0] key,
                                    input logic [PAY_PORT_W-1:0] pay);
        t_cmd c;
        c.opcode     = op;
        c.key        = key;
        c.payload_in = pay;
        return c;
    endfunction

    // Bias keys towards stored ones and their neighbours so that hits, duplicates and
    // inserts between existing entries come often.
    function automatic t_cmd make_command(input bit insert);
        int                    pick;
        int                    pay_pick;
        logic [KEY_W-1:0]      key;
        logic [PAY_PORT_W-1:0] pay;
        pick     = $urandom_range(0, 99);
        pay_pick = $urandom_range(0, 99);
        if (book.first_slot < book.fill && pick < 50) begin
            key = book.keys[$urandom_range(book.first_slot, book.fill - 1)];
        end else if (book.first_slot < book.fill && pick < 65) begin
            key = book.keys[$urandom_range(book.first_slot, book.fill - 1)]
                + (($urandom_range(0, 1) == 1) ? 32'd1 : 32'hFFFF_FFFF);
        end else if (pick < 75) begin
            key = ($urandom_range(0, 1) == 1) ? '1 : '0;
        end else begin
            key = $urandom;
        end
        if (pay_pick < 10) pay = '0;
        else if (pay_pick < 20) pay = '1;
        else pay = $urandom;
        return cmd_of(insert ? OP_INSERT : OP_LOOKUP, key, pay);
    endfunction

    initial begin
        int  sent;
        int  burst;
        int  phase_len;
        int  in_phase;
        int  want;
        bit  gaps_on;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, key and payload extremes, duplicate, shifted insert.
        write_first_slot(0);
        send_command(cmd_of(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));
        send_command(cmd_of(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_command(cmd_of(OP_INSERT, 32'h0000_0000, 32'h0000_0000));
        send_command(cmd_of(OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5));
        send_command(cmd_of(OP_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A));
        send_command(cmd_of(OP_INSERT, 32'h0000_0000, 32'h1234_5678));
        send_command(cmd_of(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF));
        send_command(cmd_of(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000));
        send_command(cmd_of(OP_LOOKUP, 32'h1234_5678, 32'h0000_0000));
        send_command(cmd_of(OP_INSERT, 32'h0000_0001, 32'h0000_0001));
        send_command(cmd_of(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000));

        // Raised lower bound: keys below it are no longer seen.
        wait_drained();
        write_first_slot(pick_first_slot(2));
        send_command(cmd_of(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));
        send_command(cmd_of(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000));
        send_command(cmd_of(OP_INSERT, 32'h0000_0002, 32'hDEAD_BEEF));

        // Lower bound past the fill: empty range, inserts land at the bound itself.
        wait_drained();
        write_first_slot(pick_first_slot(63));
        send_command(cmd_of(OP_INSERT, 32'h0000_0040, 32'hCAFE_0040));
        send_command(cmd_of(OP_LOOKUP, 32'h0000_0040, 32'h0000_0000));
        send_command(cmd_of(OP_INSERT, 32'h0000_0041, 32'hCAFE_0041));

        wait_drained();
        write_first_slot(pick_first_slot(7));
        send_command(cmd_of(OP_INSERT, 32'h0000_0050, 32'h0F0F_0F0F));
        send_command(cmd_of(OP_LOOKUP, 32'h0000_0050, 32'h0000_0000));

        // Random phases: each drains fully, rewrites first_index, then sends in bursts.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            case ($urandom_range(0, 9))
                0:       want = 0;
                1:       want = DEPTH - 1;
                default: want = $urandom_range(0, DEPTH - 1);
            endcase
            write_first_slot(pick_first_slot(want));
            gaps_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(40, 160);
            in_phase  = 0;
            burst     = $urandom_range(1, 24);
            while (in_phase < phase_len && sent < RANDOM_ITEMS) begin
                send_command(make_command($urandom_range(0, 99)
                                          < ((book.fill < DEPTH) ? 45 : 30)));
                sent++;
                in_phase++;
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 24);
                    if (gaps_on) hold_off($urandom_range(1, 15));
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.errors == 0 && book.awaited.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Backstop well beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
